// File: design/nstp_pkg.sv
// Shared types and constants of the nested section trace profiler.
`default_nettype none

package nstp_pkg;

   localparam int PATH_DEPTH_DEFAULT  = 10;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FILTER_SECTION = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FILTER_ENABLE  = 2'd1;

   localparam logic [31:0] FILTER_SECTION_RESET = 32'd1010;
   localparam logic        FILTER_ENABLE_RESET  = 1'b1;

   localparam logic [31:0] ALL_ONES  = 32'hFFFF_FFFF;
   localparam logic [15:0] DEPTH_MAX = 16'hFFFF;

   localparam logic [1:0] KIND_ENTER  = 2'd0;
   localparam logic [1:0] KIND_LEAVE  = 2'd1;
   localparam logic [1:0] KIND_REPORT = 2'd2;

   typedef enum logic [1:0] {
      OP_ENTER,
      OP_LEAVE,
      OP_REPORT
   } op_type;

   typedef enum logic {
      BK_IDLE,
      BK_REPORT
   } back_state_type;

   // One classified request as it travels through the queue.
   typedef struct packed {
      op_type      op;
      logic        filter_hit;
      logic [31:0] timestamp;
      logic [31:0] section_id;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } qslot_type;

endpackage

`default_nettype wire

// File: design/nested_section_trace_profiler.sv
// Top level of the nested section trace profiler.
//
//   channel  | direction | handshake           | payload
//   ---------+-----------+---------------------+------------------------------------
//   req_     | in        | req_valid/req_stall | kind, timestamp, section_id
//   rsp_     | out       | rsp_valid/rsp_stall | statistics, path entry, last
//   csr_     | in        | csr_valid/csr_ready | csr_index, csr_data
//
// Order: a request is written into the queue when it is accepted; the back
// end executes it from the queue head once its state machine is idle.
// A report yields max(1, min(deepest level, PATH_DEPTH)) results; its back end
// sequencer loads one result per cycle into the output register if not stalled.
// Reset: synchronous, clears control and statistics; path stores keep garbage
// until written. No clearing pass.
// Stalls: req_stall rises only when the request queue is full; rsp_stall
// holds the output register and pauses the report sequencer.
// CSR writes are taken every cycle (csr_ready is tied high).
`default_nettype none

module nested_section_trace_profiler #(
   parameter int PATH_DEPTH  = nstp_pkg::PATH_DEPTH_DEFAULT,
   parameter int QUEUE_DEPTH = nstp_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [1:0]                           req_kind,
   input  wire logic [31:0]                          req_timestamp,
   input  wire logic [31:0]                          req_section_id,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [15:0]                               rsp_deepest_level,
   output logic [31:0]                               rsp_entry_count,
   output logic [31:0]                               rsp_top_entry_count,
   output logic [31:0]                               rsp_cycle_total,
   output logic [31:0]                               rsp_cycle_longest,
   output logic [31:0]                               rsp_cycle_shortest,
   output logic [3:0]                                rsp_path_index,
   output logic [31:0]                               rsp_path_section,
   output logic                                      rsp_path_valid,
   output logic                                      rsp_last,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [nstp_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [31:0]                          csr_data
);

   nstp_pkg::qslot_type push;   // front -> queue
   nstp_pkg::qslot_type head;   // queue -> back
   logic                queue_full;
   logic                pop;

   // front: accept, decode kind, match filter id against CSRs
   nstp_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_timestamp  (req_timestamp),
      .req_section_id (req_section_id),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .queue_full     (queue_full),
      .push           (push)
   );

   // decoupling queue so a stalled report does not block the request side until the queue is full
   nstp_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .head  (head),
      .pop   (pop)
   );

   // back: depth/capture tracking, statistics, report output
   nstp_back #(
      .PATH_DEPTH (PATH_DEPTH)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .head                (head),
      .pop                 (pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_deepest_level   (rsp_deepest_level),
      .rsp_entry_count     (rsp_entry_count),
      .rsp_top_entry_count (rsp_top_entry_count),
      .rsp_cycle_total     (rsp_cycle_total),
      .rsp_cycle_longest   (rsp_cycle_longest),
      .rsp_cycle_shortest  (rsp_cycle_shortest),
      .rsp_path_index      (rsp_path_index),
      .rsp_path_section    (rsp_path_section),
      .rsp_path_valid      (rsp_path_valid),
      .rsp_last            (rsp_last)
   );

   // an empty report is always a single, final result
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_path_valid |-> rsp_last)
      else $error("empty report result without last");

   // a recorded path entry lies below the reported deepest level
   a_index_in_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_path_valid |-> rsp_deepest_level > 16'(rsp_path_index))
      else $error("path index beyond deepest level");

   // report results follow back to back with the next path index
   a_report_sequence: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=>
         rsp_valid && (rsp_path_index == $past(rsp_path_index) + 4'd1))
      else $error("report sequence broken");

   // once a nonzero duration was seen, shortest never exceeds longest
   a_min_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_cycle_longest != 32'd0) |-> rsp_cycle_shortest <= rsp_cycle_longest)
      else $error("shortest duration above longest");

endmodule

`default_nettype wire

// File: design/nstp_front.sv
// Front end: request acceptance, kind decode, filter match and CSR registers.
`default_nettype none

module nstp_front (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [1:0]                           req_kind,
   input  wire logic [31:0]                          req_timestamp,
   input  wire logic [31:0]                          req_section_id,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [nstp_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [31:0]                          csr_data,
   input  wire logic                                 queue_full,
   output nstp_pkg::qslot_type                       push
);

   logic [31:0]      filter_section_ff, filter_section_in;
   logic             filter_enable_ff, filter_enable_in;
   logic             known;
   nstp_pkg::op_type op;

   assign csr_ready = 1'b1;

   always_comb begin
      filter_section_in = filter_section_ff;
      filter_enable_in  = filter_enable_ff;
      if (csr_valid) begin
         case (csr_index)
            nstp_pkg::CSR_FILTER_SECTION: filter_section_in = csr_data;
            nstp_pkg::CSR_FILTER_ENABLE:  filter_enable_in  = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_section_ff <= nstp_pkg::FILTER_SECTION_RESET;
         filter_enable_ff  <= nstp_pkg::FILTER_ENABLE_RESET;
      end else begin
         filter_section_ff <= filter_section_in;
         filter_enable_ff  <= filter_enable_in;
      end
   end

   // unused kind code is accepted and dropped
   always_comb begin
      known = 1'b1;
      op    = nstp_pkg::OP_ENTER;
      case (req_kind)
         nstp_pkg::KIND_ENTER:  op = nstp_pkg::OP_ENTER;
         nstp_pkg::KIND_LEAVE:  op = nstp_pkg::OP_LEAVE;
         nstp_pkg::KIND_REPORT: op = nstp_pkg::OP_REPORT;
         default:               known = 1'b0;
      endcase
   end

   assign req_stall = queue_full;

   always_comb begin
      push.valid           = req_valid && known && !queue_full;
      push.item.op         = op;
      push.item.filter_hit = filter_enable_ff && (req_section_id == filter_section_ff);
      push.item.timestamp  = req_timestamp;
      push.item.section_id = req_section_id;
   end

endmodule

`default_nettype wire

// File: design/nstp_queue.sv
// Short FIFO of classified requests between front and back end.
`default_nettype none

module nstp_queue #(
   parameter int QUEUE_DEPTH = nstp_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire nstp_pkg::qslot_type  push,
   output logic                      full,
   output nstp_pkg::qslot_type       head,
   input  wire logic                 pop
);

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);
   localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);

   nstp_pkg::item_type slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]      count_ff, count_in;
   logic               do_push, do_pop;

   assign full    = (count_ff == CNT_FULL);
   assign do_push = push.valid && !full;
   assign do_pop  = pop && (count_ff != '0);

   assign head.valid = (count_ff != '0);
   assign head.item  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push.item;
      end
   end

endmodule

`default_nettype wire

// File: design/nstp_back.sv
// Back end: nesting/capture tracking, statistics and report sequencing.
`default_nettype none

module nstp_back #(
   parameter int PATH_DEPTH = nstp_pkg::PATH_DEPTH_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire nstp_pkg::qslot_type head,
   output logic                     pop,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [15:0]              rsp_deepest_level,
   output logic [31:0]              rsp_entry_count,
   output logic [31:0]              rsp_top_entry_count,
   output logic [31:0]              rsp_cycle_total,
   output logic [31:0]              rsp_cycle_longest,
   output logic [31:0]              rsp_cycle_shortest,
   output logic [3:0]               rsp_path_index,
   output logic [31:0]              rsp_path_section,
   output logic                     rsp_path_valid,
   output logic                     rsp_last
);

   localparam int IW = (PATH_DEPTH > 1) ? $clog2(PATH_DEPTH) : 1;
   localparam logic [15:0] PD16 = 16'(PATH_DEPTH);

   nstp_pkg::back_state_type state_ff, state_in;

   logic [15:0] depth_ff, depth_in;
   logic [15:0] base_ff, base_in;
   logic        capturing_ff, capturing_in;
   logic [31:0] start_ff, start_in;
   logic [15:0] deepest_ff, deepest_in;
   logic [31:0] entries_ff, entries_in;
   logic [31:0] top_ff, top_in;
   logic [31:0] sum_ff, sum_in;
   logic [31:0] max_ff, max_in;
   logic [31:0] min_ff, min_in;
   logic [31:0] current_path_ff [PATH_DEPTH];
   logic [31:0] current_path_in [PATH_DEPTH];
   logic [31:0] deepest_path_ff [PATH_DEPTH];
   logic [31:0] deepest_path_in [PATH_DEPTH];
   logic [IW-1:0] k_ff, k_in;

   logic        out_valid_ff, out_valid_in;
   logic [15:0] out_level_ff;
   logic [31:0] out_entries_ff, out_top_ff, out_sum_ff, out_max_ff, out_min_ff;
   logic [3:0]  out_index_ff;
   logic [31:0] out_section_ff;
   logic        out_pvalid_ff, out_last_ff;

   logic        do_enter, do_leave, load, clear;
   logic        starting, ends;
   logic [15:0] base_eff, rel, lvl;
   logic [31:0] dur;
   logic [15:0] n16, count16, k16;
   logic        is_last;
   logic [31:0] path_word;

   // enter datapath
   assign starting = head.item.filter_hit && !capturing_ff;
   assign base_eff = starting ? depth_ff : base_ff;
   assign rel      = depth_ff - base_eff;
   assign lvl      = (rel == nstp_pkg::DEPTH_MAX) ? nstp_pkg::DEPTH_MAX : rel + 16'd1;

   // leave datapath
   assign ends = capturing_ff && (depth_ff != 16'd0) && ((depth_ff - 16'd1) == base_ff);
   assign dur  = head.item.timestamp - start_ff;

   // report sequencing
   assign n16       = (deepest_ff < PD16) ? deepest_ff : PD16;
   assign count16   = (n16 == 16'd0) ? 16'd1 : n16;
   assign k16       = 16'(k_ff);
   assign is_last   = ((k16 + 16'd1) == count16);
   assign path_word = (n16 != 16'd0) ? deepest_path_ff[k_ff] : 32'd0;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         nstp_pkg::BK_IDLE: begin
            if (head.valid && head.item.op == nstp_pkg::OP_REPORT) begin
               state_in = nstp_pkg::BK_REPORT;
            end
         end
         nstp_pkg::BK_REPORT: begin
            if (load && is_last) begin
               state_in = nstp_pkg::BK_IDLE;
            end
         end
         default: state_in = nstp_pkg::BK_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      pop   = 1'b0;
      load  = 1'b0;
      case (state_ff)
         nstp_pkg::BK_IDLE:   pop  = head.valid;
         nstp_pkg::BK_REPORT: load = !out_valid_ff || !rsp_stall;
         default: ;
      endcase
   end

   assign do_enter = pop && (head.item.op == nstp_pkg::OP_ENTER);
   assign do_leave = pop && (head.item.op == nstp_pkg::OP_LEAVE);
   assign clear    = load && is_last;

   always_comb begin
      depth_in        = depth_ff;
      base_in         = base_ff;
      capturing_in    = capturing_ff;
      start_in        = start_ff;
      deepest_in      = deepest_ff;
      entries_in      = entries_ff;
      top_in          = top_ff;
      sum_in          = sum_ff;
      max_in          = max_ff;
      min_in          = min_ff;
      current_path_in = current_path_ff;
      deepest_path_in = deepest_path_ff;
      k_in            = k_ff;

      if (do_enter) begin
         if (depth_ff != nstp_pkg::DEPTH_MAX) begin
            depth_in = depth_ff + 16'd1;
         end
         if (starting) begin
            base_in      = depth_ff;
            capturing_in = 1'b1;
         end
         if (starting || capturing_ff) begin
            if (rel < PD16) begin
               current_path_in[rel[IW-1:0]] = head.item.section_id;
            end
            if (rel == 16'd0) begin
               start_in = head.item.timestamp;
               top_in   = top_ff + 32'd1;
            end
            entries_in = entries_ff + 32'd1;
            if (lvl > deepest_ff) begin
               deepest_in = lvl;
               // snapshot includes the id written this cycle
               for (int i = 0; i < PATH_DEPTH; i++) begin
                  if (16'(i) < lvl) begin
                     deepest_path_in[i] = (16'(i) == rel) ? head.item.section_id
                                                          : current_path_ff[i];
                  end
               end
            end
         end
      end

      if (do_leave) begin
         if (ends) begin
            sum_in       = sum_ff + dur;
            capturing_in = 1'b0;
            if (dur > max_ff) begin
               max_in = dur;
            end
            if (dur < min_ff) begin
               min_in = dur;
            end
         end
         if (depth_ff != 16'd0) begin
            depth_in = depth_ff - 16'd1;
         end
      end

      if (pop && head.item.op == nstp_pkg::OP_REPORT) begin
         k_in = '0;
      end else if (load && !is_last) begin
         k_in = k_ff + IW'(1);
      end

      if (clear) begin
         deepest_in = 16'd0;
         entries_in = 32'd0;
         top_in     = 32'd0;
         sum_in     = 32'd0;
         max_in     = 32'd0;
         min_in     = nstp_pkg::ALL_ONES;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (load) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nstp_pkg::BK_IDLE;
         depth_ff     <= 16'd0;
         base_ff      <= 16'd0;
         capturing_ff <= 1'b0;
         start_ff     <= 32'd0;
         deepest_ff   <= 16'd0;
         entries_ff   <= 32'd0;
         top_ff       <= 32'd0;
         sum_ff       <= 32'd0;
         max_ff       <= 32'd0;
         min_ff       <= nstp_pkg::ALL_ONES;
         k_ff         <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         base_ff      <= base_in;
         capturing_ff <= capturing_in;
         start_ff     <= start_in;
         deepest_ff   <= deepest_in;
         entries_ff   <= entries_in;
         top_ff       <= top_in;
         sum_ff       <= sum_in;
         max_ff       <= max_in;
         min_ff       <= min_in;
         k_ff         <= k_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // path stores and result payload: no reset
   always_ff @(posedge clock) begin
      current_path_ff <= current_path_in;
      deepest_path_ff <= deepest_path_in;
      if (load) begin
         out_level_ff   <= deepest_ff;
         out_entries_ff <= entries_ff;
         out_top_ff     <= top_ff;
         out_sum_ff     <= sum_ff;
         out_max_ff     <= max_ff;
         out_min_ff     <= min_ff;
         out_index_ff   <= (n16 != 16'd0) ? k16[3:0] : 4'd0;
         out_section_ff <= path_word;
         out_pvalid_ff  <= (n16 != 16'd0);
         out_last_ff    <= is_last;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_deepest_level   = out_level_ff;
   assign rsp_entry_count     = out_entries_ff;
   assign rsp_top_entry_count = out_top_ff;
   assign rsp_cycle_total     = out_sum_ff;
   assign rsp_cycle_longest   = out_max_ff;
   assign rsp_cycle_shortest  = out_min_ff;
   assign rsp_path_index      = out_index_ff;
   assign rsp_path_section    = out_section_ff;
   assign rsp_path_valid      = out_pvalid_ff;
   assign rsp_last            = out_last_ff;

endmodule

`default_nettype wire
